[sv/nrpc_pkg.sv]
// Shared types, constants and distance function for the nearest palette colour block.
package nrpc_pkg;

  typedef logic [23:0] rgb_t;
  typedef logic [7:0]  idx_t;
  typedef logic [9:0]  dist_t;
  typedef logic [8:0]  size_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  localparam logic  CMD_WRITE      = 1'b0;
  localparam logic  CMD_QUERY      = 1'b1;
  localparam dist_t EMPTY_DISTANCE = 10'd765;
  localparam int    INDEX_SPAN     = 256;
  localparam size_t SIZE_RESET     = 9'd16;

  function automatic logic [7:0] chan_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic dist_t rgb_distance(input rgb_t x, input rgb_t y);
    logic [7:0] dr;
    logic [7:0] dg;
    logic [7:0] db;
    dr = chan_diff(x[23:16], y[23:16]);
    dg = chan_diff(x[15:8], y[15:8]);
    db = chan_diff(x[7:0], y[7:0]);
    return {2'b00, dr} + {2'b00, dg} + {2'b00, db};
  endfunction

endpackage

[sv/nearest_palette_colour.sv]
// Top level: palette memory with a sequential nearest-colour search.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid_i/in_ready_o, cmd, entry_index, rgb    | sink
//   out     | out_valid_o/out_ready_i, best_index, best_dist  | source
//   cfg     | cfg_valid_i/cfg_ready_o, cfg_data_i             | sink
//
// A query reads min(palette_size, PALETTE_DEPTH, 256) entries, none for an
// empty search, through the single read port of the palette memory that
// yields one entry per cycle, followed by a distance stage and a compare.
// Reset clears control state and sets palette_size to 16; palette contents
// are undefined until written. A finished result waits in the output
// register; a further query may start while it waits but holds its own
// result until the output register frees.
module nearest_palette_colour #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            cmd_i,
  input  nrpc_pkg::idx_t  entry_index_i,
  input  nrpc_pkg::rgb_t  rgb_value_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output nrpc_pkg::idx_t  best_index_o,
  output nrpc_pkg::dist_t best_distance_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  nrpc_pkg::size_t cfg_data_i
);
  import nrpc_pkg::*;

  localparam int AW        = $clog2(PALETTE_DEPTH);
  localparam int XW        = (AW > 9) ? AW : 9;
  localparam int LIMIT_MAX = (PALETTE_DEPTH < INDEX_SPAN) ? PALETTE_DEPTH : INDEX_SPAN;

  rgb_t   mem [PALETTE_DEPTH];

  state_e state_q;
  size_t  size_q;
  size_t  limit_q;
  size_t  limit_d;
  size_t  rd_cnt_q;
  rgb_t   target_q;
  rgb_t   rd_data_q;
  logic   rd_vld_q;
  logic   rd_last_q;
  idx_t   rd_idx_q;
  dist_t  dst_q;
  logic   dst_vld_q;
  logic   dst_last_q;
  idx_t   dst_idx_q;
  idx_t   best_idx_q;
  dist_t  best_dist_q;
  logic   out_valid_q;

  logic          in_fire;
  logic          query_start;
  logic          wr_en;
  logic [XW-1:0] wr_ext;
  logic [XW-1:0] rd_ext;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          issue_en;
  logic          issue_last;
  logic          take;
  logic          out_load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign query_start = in_fire && (cmd_i == CMD_QUERY);
  assign wr_en       = in_fire && (cmd_i == CMD_WRITE) && (32'(entry_index_i) < PALETTE_DEPTH);
  assign wr_ext      = XW'(entry_index_i);
  assign wr_addr     = wr_ext[AW-1:0];
  assign rd_ext      = XW'(rd_cnt_q);
  assign rd_addr     = rd_ext[AW-1:0];
  assign limit_d     = (size_q > 9'(LIMIT_MAX)) ? 9'(LIMIT_MAX) : size_q;
  assign issue_en    = (state_q == S_SCAN) && (rd_cnt_q < limit_q);
  assign issue_last  = (rd_cnt_q == limit_q - 9'd1);
  assign take        = dst_vld_q && ((dst_idx_q == '0) || (dst_q < best_dist_q));
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Writes occur only in idle and reads only while scanning, so accesses never overlap.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= rgb_value_i;
    end
    if (issue_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      size_q      <= SIZE_RESET;
      rd_cnt_q    <= '0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      dst_vld_q   <= 1'b0;
      dst_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        size_q <= cfg_data_i;
      end
      rd_vld_q   <= issue_en;
      rd_last_q  <= issue_en && issue_last;
      dst_vld_q  <= rd_vld_q;
      dst_last_q <= rd_vld_q && rd_last_q;
      if (issue_en) begin
        rd_cnt_q <= rd_cnt_q + 9'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (query_start) begin
            rd_cnt_q <= '0;
            state_q  <= (limit_d == '0) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (dst_vld_q && dst_last_q) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_cnt_q[7:0];
    dst_q     <= rgb_distance(target_q, rd_data_q);
    dst_idx_q <= rd_idx_q;
    if (query_start) begin
      target_q    <= rgb_value_i;
      limit_q     <= limit_d;
      best_idx_q  <= '0;
      best_dist_q <= EMPTY_DISTANCE;
    end else if (take) begin
      best_idx_q  <= dst_idx_q;
      best_dist_q <= dst_q;
    end
    if (out_load) begin
      best_index_o    <= best_idx_q;
      best_distance_o <= best_dist_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/nrpc_checker.sv]
// Port-level checker for the nearest palette colour block, with its bind.
module nrpc_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            cmd_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input nrpc_pkg::idx_t  best_index_o,
  input nrpc_pkg::dist_t best_distance_o
);
  import nrpc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(best_index_o)
      && $stable(best_distance_o))
    else $error("result changed while stalled");

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> best_distance_o <= EMPTY_DISTANCE)
    else $error("distance out of range");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == CMD_QUERY |=> !in_ready_o)
    else $error("input ready during a query");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == CMD_WRITE && !out_valid_o |=> !out_valid_o)
    else $error("result after a write transfer");

endmodule

bind nearest_palette_colour nrpc_checker u_nrpc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .cmd_i           (cmd_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .best_index_o    (best_index_o),
  .best_distance_o (best_distance_o)
);
